// ===== design/assert_macros.svh =====
// assertion macros shared by the positional list rtl
// depends on: nothing; the user module provides i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define PLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define PLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/plc_pkg.sv =====
// types and constants of the positional list
// depends on: nothing
package plc_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 7;
    localparam int CAPACITY = 64;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // command broadcast to every cell
    typedef struct packed {
        logic              ins;
        logic              del;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } t_cmd;

endpackage

// ===== design/plc_if.sv =====
// valid/ready channels of the positional list
// depends on: plc_pkg
interface plc_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   op;
    logic [plc_pkg::POS_W-1:0]    position;
    logic signed [plc_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface plc_out_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   status;
    logic signed [plc_pkg::DATA_W-1:0] read_value;
    logic [plc_pkg::LEN_W-1:0]    length;

    modport source (output valid, output status, output read_value, output length, input ready);
    modport sink   (input valid, input status, input read_value, input length, output ready);
endinterface

// ===== design/plc_cell.sv =====
// one list cell: holds one entry, loads or shifts from a neighbor
// depends on: plc_pkg
module plc_cell #(
    parameter int INDEX = 0
) (
    input  logic                        i_clk,
    input  plc_pkg::t_cmd               i_cmd,
    input  logic [plc_pkg::DATA_W-1:0]  i_left,
    input  logic [plc_pkg::DATA_W-1:0]  i_right,
    output logic [plc_pkg::DATA_W-1:0]  o_data,
    output logic [plc_pkg::DATA_W-1:0]  o_rd
);

    localparam logic [31:0] IDX = 32'(INDEX);

    logic [plc_pkg::DATA_W-1:0] r_data;
    logic [plc_pkg::DATA_W-1:0] n_data;
    logic [31:0]                pos_w;
    logic                       at_pos;
    logic                       above_pos;

    assign pos_w     = 32'(i_cmd.pos);
    assign at_pos    = (IDX == pos_w);
    assign above_pos = (IDX > pos_w);

    always_comb begin
        n_data = r_data;
        priority if (i_cmd.ins && at_pos) begin
            n_data = i_cmd.val;
        end else if (i_cmd.ins && above_pos) begin
            n_data = i_left;
        end else if (i_cmd.del && (at_pos || above_pos)) begin
            n_data = i_right;
        end else begin
            // hold
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = at_pos ? r_data : '0;

endmodule

// ===== design/positional_list_insert_delete.sv =====
// top level of the positional list: control, length counter, row of cells
// depends on: plc_pkg, plc_if, plc_cell, assert_macros.svh
//
// Positional list of signed 32-bit words held in a row of CAPACITY cells, one entry
// per cell. An insert, delete or read is taken on i_in and gives exactly one result on
// o_out from the result register (status, read word, new length). All cells compare the
// position against their own index in the same cycle and each chooses to hold, load
// the new word, or take its left or right neighbor, so the whole shift finishes in
// the cycle of the transfer. One item is taken per cycle as long as the result
// register is empty or being drained; i_in.ready falls only while a result waits
// on a stalled o_out. Status codes: 0 ok, 1 bad position (also for the unused op
// code), 2 list full on insert, 3 list empty on delete or read. The full check comes
// before the position check. read_value is zero except for a successful read. No
// clearing pass is needed after reset: only entries below the length are ever read.
`include "assert_macros.svh"

module positional_list_insert_delete #(
    parameter int CAPACITY = plc_pkg::CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    plc_in_if.sink        i_in,
    plc_out_if.source     o_out
);

    // count must hold the capacity itself
    localparam int CW    = $clog2(CAPACITY + 1);
    // compare width covers both the count and the position field
    localparam int CMP_W = (CW > plc_pkg::LEN_W) ? CW : plc_pkg::LEN_W;

    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic                          r_out_valid;
    plc_pkg::t_status              r_status;
    plc_pkg::t_status              n_status;
    logic [plc_pkg::DATA_W-1:0]    r_read_value;
    logic [plc_pkg::DATA_W-1:0]    n_read_value;

    logic                          acc;
    logic                          do_ins;
    logic                          do_del;
    logic                          rd_ok;
    logic                          full;
    logic                          empty;
    logic [CMP_W-1:0]              pos_c;
    logic [CMP_W-1:0]              cnt_c;
    plc_pkg::t_cmd                 cmd;
    logic [plc_pkg::DATA_W-1:0]    rd_or;

    logic [plc_pkg::DATA_W-1:0]    cell_data [CAPACITY];
    logic [plc_pkg::DATA_W-1:0]    cell_rd   [CAPACITY];

    // handshake: the result register frees up as it is drained
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && i_in.ready;

    assign pos_c = CMP_W'(i_in.position);
    assign cnt_c = CMP_W'(r_count);
    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    // operation decode and status priority
    always_comb begin
        n_status = plc_pkg::ST_BADPOS;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        rd_ok    = 1'b0;
        unique case (i_in.op)
            plc_pkg::OP_INSERT: begin
                if (full) begin
                    n_status = plc_pkg::ST_FULL;
                end else if (pos_c > cnt_c) begin
                    n_status = plc_pkg::ST_BADPOS;
                end else begin
                    n_status = plc_pkg::ST_OK;
                    do_ins   = 1'b1;
                end
            end
            plc_pkg::OP_DELETE: begin
                if (empty) begin
                    n_status = plc_pkg::ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    n_status = plc_pkg::ST_BADPOS;
                end else begin
                    n_status = plc_pkg::ST_OK;
                    do_del   = 1'b1;
                end
            end
            plc_pkg::OP_READ: begin
                if (empty) begin
                    n_status = plc_pkg::ST_EMPTY;
                end else if (pos_c >= cnt_c) begin
                    n_status = plc_pkg::ST_BADPOS;
                end else begin
                    n_status = plc_pkg::ST_OK;
                    rd_ok    = 1'b1;
                end
            end
            default: begin
                // unused op code changes nothing
                n_status = plc_pkg::ST_BADPOS;
            end
        endcase
    end

    // broadcast command, qualified by the transfer
    assign cmd.ins = acc && do_ins;
    assign cmd.del = acc && do_del;
    assign cmd.pos = i_in.position;
    assign cmd.val = i_in.value;

    // row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [plc_pkg::DATA_W-1:0] left_in;
        logic [plc_pkg::DATA_W-1:0] right_in;

        if (g == 0) begin : g_first
            // never shifts from the left: cell 0 is never above the position
            assign left_in = i_in.value;
        end else begin : g_mid_l
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // last cell falls outside the list after a delete, keep its word
            assign right_in = cell_data[g];
        end else begin : g_mid_r
            assign right_in = cell_data[g+1];
        end

        plc_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (left_in),
            .i_right (right_in),
            .o_data  (cell_data[g]),
            .o_rd    (cell_rd[g])
        );
    end

    // one-hot read: only the cell at the position drives nonzero data
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    assign n_read_value = rd_ok ? rd_or : '0;

    always_comb begin
        n_count = r_count;
        if (cmd.ins) begin
            n_count = r_count + CW'(1);
        end else if (cmd.del) begin
            n_count = r_count - CW'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on each transfer
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.read_value = r_read_value;
    // length of the result is the count after the operation
    assign o_out.length     = plc_pkg::LEN_W'(r_count);

    `PLC_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(CAPACITY), "list length above capacity")
    `PLC_ASSERT_NEXT(a_insert_grows, cmd.ins, r_count == $past(r_count) + CW'(1), "insert did not grow length")
    `PLC_ASSERT_NEXT(a_reject_holds, acc && (n_status != plc_pkg::ST_OK), $stable(r_count), "rejected op changed length")
    `PLC_ASSERT_ALWAYS(a_rd_zero, !(r_out_valid && (r_status != plc_pkg::ST_OK)) || (r_read_value == '0), "read word nonzero on failed op")

endmodule
